FILE: rtl/ali_pkg.sv
package ali_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;
    localparam int MIDX_W = 6;
    localparam int CMD_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESIZE = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_READ   = 3'd3,
        CMD_WRITE  = 3'd4,
        CMD_FIND   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SHIFT,
        ST_RD,
        ST_FIND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              ok;
        logic              found;
        logic [MIDX_W-1:0] match_index;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  length;
    } t_result;

endpackage

FILE: rtl/ali_mem.sv
module ali_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ali_pkg::DATA_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [ali_pkg::DATA_W-1:0] o_rdata
);

    logic [ali_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [ali_pkg::DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ali_seq.sv
module ali_seq #(
    parameter int CAPACITY = 64,
    parameter int AW       = $clog2(CAPACITY),
    parameter int FW       = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ali_pkg::CMD_W-1:0]   i_command,
    input  logic [ali_pkg::POS_W-1:0]   i_position,
    input  logic [ali_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_out_free,
    output logic                        o_res_valid,
    output ali_pkg::t_result            o_res,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [ali_pkg::DATA_W-1:0]  o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [ali_pkg::DATA_W-1:0]  i_mem_rdata
);

    localparam int CW = (FW > ali_pkg::POS_W) ? FW : ali_pkg::POS_W;
    localparam int MW = (AW > ali_pkg::MIDX_W) ? AW : ali_pkg::MIDX_W;
    localparam int LW = (CW > ali_pkg::LEN_W) ? CW : ali_pkg::LEN_W;

    ali_pkg::t_state r_state, n_state;

    logic [ali_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [CW-1:0]              r_pos, n_pos;
    logic [ali_pkg::DATA_W-1:0] r_val, n_val;
    logic [FW-1:0]              r_fill, n_fill;
    logic [FW-1:0]              r_k, n_k;
    logic [AW-1:0]              r_wk, n_wk;
    logic                       r_pend, n_pend;
    logic                       r_ok, n_ok;
    logic                       r_found, n_found;
    logic [AW-1:0]              r_midx, n_midx;
    logic [ali_pkg::DATA_W-1:0] r_rval, n_rval;

    logic [CW-1:0] fill_w, k_w, cap_w;
    logic          c_pos_le_cap, c_pos_le_fill, c_pos_lt_fill, c_fill_lt_cap;
    logic          c_k_lt_pos, c_k_gt_pos, c_k_lt_fill, c_hit;
    logic [MW-1:0] midx_w;
    logic [LW-1:0] len_w;

    // range checks on common width
    assign fill_w        = CW'(r_fill);
    assign k_w           = CW'(r_k);
    assign cap_w         = CW'(CAPACITY);
    assign c_pos_le_cap  = (r_pos <= cap_w);
    assign c_pos_le_fill = (r_pos <= fill_w);
    assign c_pos_lt_fill = (r_pos < fill_w);
    assign c_fill_lt_cap = (fill_w < cap_w);
    assign c_k_lt_pos    = (k_w < r_pos);
    assign c_k_gt_pos    = (k_w > r_pos);
    assign c_k_lt_fill   = (k_w < fill_w);
    assign c_hit         = r_pend && (i_mem_rdata == r_val);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ali_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ali_pkg::ST_EXEC;
                end
            end
            ali_pkg::ST_EXEC: begin
                unique case (r_cmd)
                    ali_pkg::CMD_RESIZE: begin
                        n_state = c_pos_le_cap ? ali_pkg::ST_FILL : ali_pkg::ST_DONE;
                    end
                    ali_pkg::CMD_INSERT: begin
                        n_state = (c_pos_le_fill && c_fill_lt_cap) ?
                                  ali_pkg::ST_SHIFT : ali_pkg::ST_DONE;
                    end
                    ali_pkg::CMD_READ: begin
                        n_state = c_pos_lt_fill ? ali_pkg::ST_RD : ali_pkg::ST_DONE;
                    end
                    ali_pkg::CMD_FIND: begin
                        n_state = ali_pkg::ST_FIND;
                    end
                    default: begin
                        n_state = ali_pkg::ST_DONE;
                    end
                endcase
            end
            ali_pkg::ST_FILL: begin
                if (!c_k_lt_pos) begin
                    n_state = ali_pkg::ST_DONE;
                end
            end
            ali_pkg::ST_SHIFT: begin
                if (!c_k_gt_pos && !r_pend) begin
                    n_state = ali_pkg::ST_DONE;
                end
            end
            ali_pkg::ST_RD: begin
                n_state = ali_pkg::ST_DONE;
            end
            ali_pkg::ST_FIND: begin
                if (c_hit || !c_k_lt_fill) begin
                    n_state = ali_pkg::ST_DONE;
                end
            end
            ali_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = ali_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ali_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory accesses
    always_comb begin
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_val       = r_val;
        n_fill      = r_fill;
        n_k         = r_k;
        n_wk        = r_wk;
        n_pend      = r_pend;
        n_ok        = r_ok;
        n_found     = r_found;
        n_midx      = r_midx;
        n_rval      = r_rval;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        unique case (r_state)
            ali_pkg::ST_IDLE: begin
                // capture the item
                if (i_in_valid) begin
                    n_cmd = i_command;
                    n_pos = CW'(i_position);
                    n_val = i_value;
                end
            end
            ali_pkg::ST_EXEC: begin
                n_ok    = 1'b0;
                n_found = 1'b0;
                n_midx  = '0;
                n_rval  = '0;
                n_pend  = 1'b0;
                unique case (r_cmd)
                    ali_pkg::CMD_RESIZE: begin
                        n_ok = c_pos_le_cap;
                        n_k  = r_fill;
                    end
                    ali_pkg::CMD_INSERT: begin
                        n_ok = c_pos_le_fill && c_fill_lt_cap;
                        n_k  = r_fill;
                    end
                    ali_pkg::CMD_APPEND: begin
                        if (c_fill_lt_cap) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_fill);
                            o_mem_wdata = r_val;
                            n_fill      = r_fill + 1'b1;
                            n_ok        = 1'b1;
                        end
                    end
                    ali_pkg::CMD_READ: begin
                        if (c_pos_lt_fill) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = AW'(r_pos);
                            n_ok        = 1'b1;
                        end
                    end
                    ali_pkg::CMD_WRITE: begin
                        if (c_pos_lt_fill) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_pos);
                            o_mem_wdata = r_val;
                            n_ok        = 1'b1;
                        end
                    end
                    ali_pkg::CMD_FIND: begin
                        n_ok = 1'b1;
                        n_k  = '0;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            ali_pkg::ST_FILL: begin
                // zero the entries that growth adds, then set the count
                if (c_k_lt_pos) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(r_k);
                    o_mem_wdata = '0;
                    n_k         = r_k + 1'b1;
                end else begin
                    n_fill = FW'(r_pos);
                end
            end
            ali_pkg::ST_SHIFT: begin
                // move the word read last cycle one place up
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wk;
                    o_mem_wdata = i_mem_rdata;
                end
                if (c_k_gt_pos) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_k - 1'b1);
                    n_wk        = AW'(r_k);
                    n_k         = r_k - 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = AW'(r_pos);
                        o_mem_wdata = r_val;
                        n_fill      = r_fill + 1'b1;
                    end
                end
            end
            ali_pkg::ST_RD: begin
                n_rval = i_mem_rdata;
            end
            ali_pkg::ST_FIND: begin
                // compare the word read last cycle, keep reading upward
                if (c_hit) begin
                    n_found = 1'b1;
                    n_midx  = r_wk;
                    n_pend  = 1'b0;
                end else if (c_k_lt_fill) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_k);
                    n_wk        = AW'(r_k);
                    n_k         = r_k + 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            ali_pkg::ST_DONE: begin
                n_pend = 1'b0;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ali_pkg::ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_k     <= n_k;
        r_wk    <= n_wk;
        r_ok    <= n_ok;
        r_found <= n_found;
        r_midx  <= n_midx;
        r_rval  <= n_rval;
    end

    // result toward the output register
    assign midx_w            = MW'(r_midx);
    assign len_w             = LW'(r_fill);
    assign o_in_ready        = (r_state == ali_pkg::ST_IDLE);
    assign o_res_valid       = (r_state == ali_pkg::ST_DONE) && i_out_free;
    assign o_res.ok          = r_ok;
    assign o_res.found       = r_found;
    assign o_res.match_index = midx_w[ali_pkg::MIDX_W-1:0];
    assign o_res.read_value  = r_rval;
    assign o_res.length      = len_w[ali_pkg::LEN_W-1:0];

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fill) <= cap_w)
        else $error("fill count above capacity");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ali_pkg::ST_IDLE) |-> !o_mem_we)
        else $error("memory write while idle");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("read and write hit the same entry");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_state == ali_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after result");
`endif

endmodule

FILE: rtl/array_list_insert_search_top.sv
// Bounded list of signed 32-bit words with a fill count, driven by one
// command per item (resize, insert, append, read, write, find); every item
// yields exactly one result. The words live in a single-port-write,
// registered-read memory and a sequencer walks it one entry per cycle, so
// items are handled one at a time. Append, write and refused commands pass
// through the execute and done states; a read also takes the memory word
// in a read state, a resize that grows zero-fills the added entries, an
// insert shifts the entries at and above the position up one place and
// then stores the value, and a find reads upward until a hit or the end.
// The result sits in an output register, so the next item is accepted
// while it waits. The memory needs no clearing after reset: entries become
// readable only after resize, insert, append or write has stored them.
module array_list_insert_search_top #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic [6:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_ok,
    output logic               o_found,
    output logic [5:0]         o_match_index,
    output logic signed [31:0] o_read_value,
    output logic [6:0]         o_length
);

    localparam int AW = $clog2(CAPACITY);

    logic                       out_free;
    logic                       res_valid;
    ali_pkg::t_result           res;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [ali_pkg::DATA_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [ali_pkg::DATA_W-1:0] mem_rdata;

    logic             r_out_valid;
    ali_pkg::t_result r_out;

    assign out_free = !r_out_valid || i_out_ready;

    ali_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ali_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // hold the result until the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out.ok;
    assign o_found       = r_out.found;
    assign o_match_index = r_out.match_index;
    assign o_read_value  = r_out.read_value;
    assign o_length      = r_out.length;

endmodule

FILE: tb/tb_array_list_insert_search_top.sv
`timescale 1ns / 100ps

module tb_array_list_insert_search_top;

    localparam int CAPACITY    = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 80;
    localparam int RAND_ITEMS  = 600;
    localparam int QUIET_FROM  = 480;

    // Codes outside the command set, expected to be refused
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    // Shadow of the list: predicts each result and holds the pending ones
    class list_scoreboard;
        logic [31:0]      words [CAPACITY];
        int unsigned      fill;
        ali_pkg::t_result pending [$];
        int unsigned      checked;
        int unsigned      errors;
        int unsigned      refused;
        int unsigned      find_hits;

        function new();
            foreach (words[k]) words[k] = '0;
            fill      = 0;
            checked   = 0;
            errors    = 0;
            refused   = 0;
            find_hits = 0;
        endfunction

        // Apply one command to the shadow list and return its result
        function ali_pkg::t_result apply_command(logic [2:0] cmd, logic [6:0] pos,
                                                 logic [31:0] val);
            ali_pkg::t_result r;
            int               k;
            r = '0;
            case (ali_pkg::t_cmd'(cmd))
                ali_pkg::CMD_RESIZE: begin
                    if (pos <= CAPACITY) begin
                        for (k = fill; k < pos; k++) words[k] = '0;
                        fill = 32'(pos);
                        r.ok = 1'b1;
                    end
                end
                ali_pkg::CMD_INSERT: begin
                    if (pos <= fill && fill < CAPACITY) begin
                        for (k = fill; k > pos; k--) words[k] = words[k-1];
                        words[pos] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                ali_pkg::CMD_APPEND: begin
                    if (fill < CAPACITY) begin
                        words[fill] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                ali_pkg::CMD_READ: begin
                    if (pos < fill) begin
                        r.read_value = words[pos];
                        r.ok = 1'b1;
                    end
                end
                ali_pkg::CMD_WRITE: begin
                    if (pos < fill) begin
                        words[pos] = val;
                        r.ok = 1'b1;
                    end
                end
                ali_pkg::CMD_FIND: begin
                    r.ok = 1'b1;
                    for (k = 0; k < fill; k++) begin
                        if (!r.found && words[k] == val) begin
                            r.found       = 1'b1;
                            r.match_index = k[ali_pkg::MIDX_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
            r.length = fill[ali_pkg::LEN_W-1:0];
            return r;
        endfunction

        function void note_item(logic [2:0] cmd, logic [6:0] pos, logic [31:0] val);
            ali_pkg::t_result r;
            r = apply_command(cmd, pos, val);
            if (!r.ok) refused++;
            if (r.found) find_hits++;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(ali_pkg::t_result got);
            ali_pkg::t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: ok=%0b found=%0b idx=%0d rd=%h len=%0d",
                             got.ok, got.found, got.match_index, got.read_value, got.length);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.ok !== want.ok || got.found !== want.found ||
                got.match_index !== want.match_index ||
                got.read_value !== want.read_value || got.length !== want.length) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on result %0d: expected ok=%0b found=%0b idx=%0d ",
                             checked, want.ok, want.found, want.match_index,
                             "rd=%h len=%0d, got ok=%0b found=%0b idx=%0d rd=%h len=%0d",
                             want.read_value, want.length, got.ok, got.found,
                             got.match_index, got.read_value, got.length);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_command;
    logic [6:0]         i_position;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_ok;
    logic               o_found;
    logic [5:0]         o_match_index;
    logic signed [31:0] o_read_value;
    logic [6:0]         o_length;

    list_scoreboard   sb;
    ali_pkg::t_result got;
    logic             quiet;
    logic             idle_ok;
    int unsigned      cyc_count;
    int unsigned      stuck;
    int unsigned      stall_left;
    int unsigned      cmd_count [8];

    array_list_insert_search_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_found       (o_found),
        .o_match_index (o_match_index),
        .o_read_value  (o_read_value),
        .o_length      (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle only outside the final stretch and while bit 7 of the cycle count is clear
    assign idle_ok = !quiet && !cyc_count[7];

    // Hold off results in short random bursts
    initial begin
        i_out_ready = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (!idle_ok) begin
                i_out_ready = 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 4) == 0) begin
                i_out_ready = 1'b0;
                stall_left  = $urandom_range(0, 2);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Check results, then note accepted items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.ok          = o_ok;
                got.found       = o_found;
                got.match_index = o_match_index;
                got.read_value  = o_read_value;
                got.length      = o_length;
                sb.check_result(got);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_item(i_command, i_position, i_value);
                cmd_count[i_command]++;
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        cyc_count++;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck = 0;
        end else begin
            stuck++;
            if (stuck >= STALL_LIMIT) begin
                $display("tb_array_list_insert_search_top failed");
                $finish;
            end
        end
    end

    // Present one item from a falling edge and hold it until accepted
    task automatic send_item(input logic [2:0] cmd, input logic [6:0] pos,
                             input logic [31:0] val);
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_position = pos;
        i_value    = val;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // Pick a random command, aimed mostly at legal positions
    task automatic send_random();
        int unsigned  sel;
        int unsigned  len;
        logic [2:0]   cmd;
        logic [6:0]   pos;
        logic [31:0]  val;
        sel = $urandom_range(0, 99);
        len = sb.fill;
        val = pick_word();
        pos = 7'($urandom_range(0, 127));
        if (sel < 8) begin
            cmd = ali_pkg::CMD_RESIZE;
            if ($urandom_range(0, 4) != 0) pos = 7'($urandom_range(0, CAPACITY));
        end else if (sel < 33) begin
            cmd = ali_pkg::CMD_INSERT;
            if ($urandom_range(0, 6) != 0) pos = 7'($urandom_range(0, len));
        end else if (sel < 48) begin
            cmd = ali_pkg::CMD_APPEND;
        end else if (sel < 63) begin
            cmd = ali_pkg::CMD_READ;
            if (len > 0 && $urandom_range(0, 6) != 0) pos = 7'($urandom_range(0, len - 1));
        end else if (sel < 78) begin
            cmd = ali_pkg::CMD_WRITE;
            if (len > 0 && $urandom_range(0, 6) != 0) pos = 7'($urandom_range(0, len - 1));
        end else if (sel < 97) begin
            cmd = ali_pkg::CMD_FIND;
            if (len > 0 && $urandom_range(0, 4) < 3) val = sb.words[$urandom_range(0, len - 1)];
        end else begin
            cmd = $urandom_range(0, 1) ? CMD_BAD_HI : CMD_BAD_LO;
        end
        send_item(cmd, pos, val);
    endtask

    initial begin
        int unsigned n;
        int unsigned leftover;
        sb         = new();
        quiet      = 1'b0;
        cyc_count  = 0;
        stuck      = 0;
        foreach (cmd_count[k]) cmd_count[k] = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_command  = '0;
        i_position = '0;
        i_value    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list: everything positional is refused, find misses
        send_item(ali_pkg::CMD_READ,   7'd0,   32'd0);
        send_item(ali_pkg::CMD_FIND,   7'd0,   32'd0);
        send_item(ali_pkg::CMD_WRITE,  7'd0,   32'd9);
        send_item(ali_pkg::CMD_INSERT, 7'd1,   32'd9);
        // Grow to capacity with zero fill, then try to overfill
        send_item(ali_pkg::CMD_RESIZE, 7'd64,  32'd0);
        send_item(ali_pkg::CMD_APPEND, 7'd0,   32'd3);
        send_item(ali_pkg::CMD_INSERT, 7'd0,   32'd3);
        send_item(ali_pkg::CMD_FIND,   7'd0,   32'd0);
        // Extreme words at both ends, find at the top index
        send_item(ali_pkg::CMD_WRITE,  7'd63,  32'h8000_0000);
        send_item(ali_pkg::CMD_WRITE,  7'd0,   32'h7fff_ffff);
        send_item(ali_pkg::CMD_FIND,   7'd0,   32'h8000_0000);
        send_item(ali_pkg::CMD_READ,   7'd63,  32'd0);
        send_item(ali_pkg::CMD_READ,   7'd64,  32'd0);
        // Oversized resize and unknown codes leave the list alone
        send_item(ali_pkg::CMD_RESIZE, 7'd65,  32'd0);
        send_item(ali_pkg::CMD_RESIZE, 7'd127, 32'hffff_ffff);
        send_item(CMD_BAD_LO,          7'd127, 32'hffff_ffff);
        // Shrink to empty and rebuild with inserts at front, middle and end
        send_item(ali_pkg::CMD_RESIZE, 7'd0,   32'd0);
        send_item(ali_pkg::CMD_INSERT, 7'd0,   32'd1);
        send_item(ali_pkg::CMD_APPEND, 7'd0,   32'hffff_ffff);
        send_item(ali_pkg::CMD_INSERT, 7'd1,   32'd5);
        send_item(ali_pkg::CMD_INSERT, 7'd3,   32'd7);
        send_item(ali_pkg::CMD_INSERT, 7'd5,   32'd8);
        send_item(ali_pkg::CMD_FIND,   7'd0,   32'd12345);
        // Regrowth zero-fills entries written earlier
        send_item(ali_pkg::CMD_RESIZE, 7'd6,   32'd0);
        send_item(ali_pkg::CMD_READ,   7'd5,   32'd0);

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == QUIET_FROM) quiet = 1'b1;
            send_random();
        end
        i_in_valid = 1'b0;

        // Drain, then watch for stray results
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        leftover = sb.pending.size();

        $display("checked %0d results: %0d resize, %0d insert, %0d append, ",
                 sb.checked, cmd_count[ali_pkg::CMD_RESIZE],
                 cmd_count[ali_pkg::CMD_INSERT], cmd_count[ali_pkg::CMD_APPEND],
                 "%0d read, %0d write, %0d find, %0d unknown",
                 cmd_count[ali_pkg::CMD_READ], cmd_count[ali_pkg::CMD_WRITE],
                 cmd_count[ali_pkg::CMD_FIND],
                 cmd_count[CMD_BAD_LO] + cmd_count[CMD_BAD_HI]);
        $display("%0d refused, %0d finds hit, %0d errors, %0d still pending",
                 sb.refused, sb.find_hits, sb.errors, leftover);
        if (sb.errors == 0 && leftover == 0) begin
            $display("tb_array_list_insert_search_top passed");
        end else begin
            $display("tb_array_list_insert_search_top failed");
        end
        $finish;
    end

endmodule
